@@ design/pcea_pkg.sv @@
// Package for the point cloud edge trim block.
// Holds widths, codes and the command/status words shared by all modules.
// Depends on nothing.
package pcea_pkg;

   // Default sizes of the histogram storage.
   localparam int MAX_BINS_DEF   = 1024;
   localparam int COUNT_BITS_DEF = 24;

   // Fixed field widths.
   localparam int TYPE_W  = 2;
   localparam int COORD_W = 24;
   localparam int BW_W    = 16;
   localparam int TOL_W   = 17;
   localparam int TRIM_W  = 26;
   localparam int DVD_W   = 26;
   localparam int DVS_W   = 17;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // Register reset values.
   localparam logic [BW_W-1:0]  BIN_WIDTH_RST = 16'd3000;
   localparam logic [TOL_W-1:0] TRIM_TOL_RST  = 17'd0;

   // Register indexes, taken from paddr bit 2.
   localparam logic REG_BIN_WIDTH = 1'b0;
   localparam logic REG_TRIM_TOL  = 1'b1;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_EXTENT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_COUNT  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_FINISH = 2'd2;

   // Which division the shared divider works on.
   typedef enum logic [1:0] {
      DIV_BINS_X,
      DIV_BINS_Y,
      DIV_IDX_X,
      DIV_IDX_Y
   } div_sel_type;

   // Kinds of sweep over the histogram memories.
   typedef enum logic [1:0] {
      PASS_COUNT,
      PASS_SEARCH,
      PASS_TRIM,
      PASS_CLEAR
   } pass_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          ext_upd;
      logic          pt_load;
      logic          div_start;
      div_sel_type   div_sel;
      logic          pt_rd;
      logic          pt_wr;
      logic          pass_start;
      pass_kind_type pass_kind;
      logic          cnt_fin;
      logic          srch_upd;
      logic          thr_mul;
      logic          trim_mul;
   } pcea_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic bins_ok;
      logic pass_done;
      logic srch_done;
   } pcea_status_type;

endpackage

@@ design/pcea_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses widths from pcea_pkg.
module pcea_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pcea_pkg::DVD_W-1:0]  dividend,
   input  logic [pcea_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [pcea_pkg::DVD_W-1:0]  quotient
);
   import pcea_pkg::*;

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_sub;
   logic             ge;

   // One shift-and-subtract step.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CW'(DVD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = rem_sub[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dvs_ff <= divisor;
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/pcea_csr.sv @@
// Configuration registers behind the APB-style port.
// Uses register indexes and reset values from pcea_pkg.
module pcea_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pcea_pkg::CSR_AW-1:0]  paddr,
   input  logic [pcea_pkg::CSR_DW-1:0]  pwdata,
   output logic [pcea_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready,
   output logic [pcea_pkg::BW_W-1:0]    bin_width,
   output logic [pcea_pkg::TOL_W-1:0]   trim_tol,
   output logic                         width_wr
);
   import pcea_pkg::*;

   logic [BW_W-1:0]  bw_ff;
   logic [TOL_W-1:0] tol_ff;
   logic             wr;
   logic             idx;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[2];

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff  <= BIN_WIDTH_RST;
         tol_ff <= TRIM_TOL_RST;
      end else if (wr) begin
         unique case (idx)
            REG_BIN_WIDTH: bw_ff  <= pwdata[BW_W-1:0];
            REG_TRIM_TOL:  tol_ff <= pwdata[TOL_W-1:0];
            default:       bw_ff  <= bw_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      unique case (idx)
         REG_BIN_WIDTH: prdata = CSR_DW'(bw_ff);
         REG_TRIM_TOL:  prdata = CSR_DW'(tol_ff);
         default:       prdata = '0;
      endcase
   end

   assign width_wr  = wr && (idx == REG_BIN_WIDTH);
   assign bin_width = bw_ff;
   assign trim_tol  = tol_ff;

endmodule

@@ design/pcea_datapath.sv @@
// Datapath: extents, bin counts, histogram memories, sweeps and trims.
// Uses pcea_pkg and instantiates pcea_div.
module pcea_datapath #(
   parameter int MAX_BINS   = pcea_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = pcea_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pcea_pkg::pcea_cmd_type             cmd,
   output pcea_pkg::pcea_status_type          status,
   input  logic signed [pcea_pkg::COORD_W-1:0] point_x,
   input  logic signed [pcea_pkg::COORD_W-1:0] point_y,
   input  logic [pcea_pkg::BW_W-1:0]          bin_width,
   input  logic [pcea_pkg::TOL_W-1:0]         trim_tol,
   input  logic                               width_wr,
   output logic [pcea_pkg::TRIM_W-1:0]        trim_north,
   output logic [pcea_pkg::TRIM_W-1:0]        trim_south,
   output logic [pcea_pkg::TRIM_W-1:0]        trim_east,
   output logic [pcea_pkg::TRIM_W-1:0]        trim_west,
   output logic                               no_data,
   output logic                               bins_clamped
);
   import pcea_pkg::*;

   localparam int NB = $clog2(MAX_BINS + 1);
   localparam int AB = $clog2(MAX_BINS);
   localparam int CB = COUNT_BITS;
   localparam int TW = CB + TOL_W;
   localparam int PW = NB + BW_W;
   localparam logic [CB-1:0] COUNT_MAX = '1;
   localparam logic [AB-1:0] LAST_ADDR = AB'(MAX_BINS - 1);

   logic [BW_W-1:0] eff_w;
   assign eff_w = (bin_width == '0) ? BW_W'(1) : bin_width;

   // Extents and latched point.
   logic signed [COORD_W-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff, px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xlo_ff <= {1'b0, {(COORD_W-1){1'b1}}};
         ylo_ff <= {1'b0, {(COORD_W-1){1'b1}}};
         xhi_ff <= {1'b1, {(COORD_W-1){1'b0}}};
         yhi_ff <= {1'b1, {(COORD_W-1){1'b0}}};
      end else if (cmd.ext_upd) begin
         if (point_x < xlo_ff) xlo_ff <= point_x;
         if (point_x > xhi_ff) xhi_ff <= point_x;
         if (point_y < ylo_ff) ylo_ff <= point_y;
         if (point_y > yhi_ff) yhi_ff <= point_y;
      end
      if (cmd.pt_load) begin
         px_ff <= point_x;
         py_ff <= point_y;
      end
   end

   // Divider operands.
   logic signed [COORD_W:0] xr, yr, dx, dy;
   logic [DVD_W-1:0] dvd;
   logic [DVS_W-1:0] dvs;
   logic [DVD_W-1:0] quo;
   logic             div_done;

   always_comb begin
      xr = {xhi_ff[COORD_W-1], xhi_ff} - {xlo_ff[COORD_W-1], xlo_ff};
      yr = {yhi_ff[COORD_W-1], yhi_ff} - {ylo_ff[COORD_W-1], ylo_ff};
      dx = {px_ff[COORD_W-1], px_ff} - {xlo_ff[COORD_W-1], xlo_ff};
      dy = {py_ff[COORD_W-1], py_ff} - {ylo_ff[COORD_W-1], ylo_ff};
      unique case (cmd.div_sel)
         DIV_BINS_X: begin
            dvd = DVD_W'({xr[COORD_W-1:0], 1'b0}) + DVD_W'(eff_w);
            dvs = {eff_w, 1'b0};
         end
         DIV_BINS_Y: begin
            dvd = DVD_W'({yr[COORD_W-1:0], 1'b0}) + DVD_W'(eff_w);
            dvs = {eff_w, 1'b0};
         end
         DIV_IDX_X: begin
            dvd = DVD_W'(dx[COORD_W-1:0]);
            dvs = {1'b0, eff_w};
         end
         default: begin
            dvd = DVD_W'(dy[COORD_W-1:0]);
            dvs = {1'b0, eff_w};
         end
      endcase
   end

   pcea_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo)
   );

   // Bin counts, clamp flags and point indexes from the divider.
   logic [NB-1:0] nx_ff, ny_ff;
   logic          clamp_x_ff, clamp_y_ff, bins_ok_ff;
   logic [AB-1:0] idx_x_ff, idx_y_ff;
   logic          hit_x_ff, hit_y_ff;
   logic          big;

   assign big = quo > DVD_W'(MAX_BINS);

   always_ff @(posedge clock) begin
      if (div_done) begin
         unique case (cmd.div_sel)
            DIV_BINS_X: begin
               nx_ff      <= (xlo_ff > xhi_ff) ? '0 : (big ? NB'(MAX_BINS) : NB'(quo));
               clamp_x_ff <= (xlo_ff <= xhi_ff) && big;
            end
            DIV_BINS_Y: begin
               ny_ff      <= (ylo_ff > yhi_ff) ? '0 : (big ? NB'(MAX_BINS) : NB'(quo));
               clamp_y_ff <= (ylo_ff <= yhi_ff) && big;
            end
            DIV_IDX_X: begin
               idx_x_ff <= quo[AB-1:0];
               hit_x_ff <= !(px_ff < xlo_ff) && (quo < DVD_W'(nx_ff));
            end
            default: begin
               idx_y_ff <= quo[AB-1:0];
               hit_y_ff <= !(py_ff < ylo_ff) && (quo < DVD_W'(ny_ff));
            end
         endcase
      end
      // Cached bin counts go stale when extents or width change.
      if (reset || cmd.ext_upd || width_wr) begin
         bins_ok_ff <= 1'b0;
      end else if (div_done && cmd.div_sel == DIV_BINS_Y) begin
         bins_ok_ff <= 1'b1;
      end
   end

   // Sweep address generator with read pipeline tracking.
   logic          scan_run_ff, rd_vld_ff, rd_last_ff;
   logic [AB-1:0] scan_addr_ff, rd_idx_ff;
   pass_kind_type kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         rd_vld_ff  <= scan_run_ff;
         rd_last_ff <= scan_run_ff && (scan_addr_ff == LAST_ADDR);
         if (cmd.pass_start) begin
            scan_run_ff <= 1'b1;
         end else if (scan_run_ff && scan_addr_ff == LAST_ADDR) begin
            scan_run_ff <= 1'b0;
         end
      end
      rd_idx_ff <= scan_addr_ff;
      if (cmd.pass_start) begin
         scan_addr_ff <= '0;
         kind_ff      <= cmd.pass_kind;
      end else if (scan_run_ff) begin
         scan_addr_ff <= scan_addr_ff + 1'b1;
      end
   end

   // Histogram memories, one read and one write port each.
   logic [CB-1:0] x_hist_mem [MAX_BINS];
   logic [CB-1:0] y_hist_mem [MAX_BINS];
   logic [CB-1:0] rd_x_ff, rd_y_ff;
   logic [AB-1:0] ra_x, ra_y;
   logic          clr;

   assign ra_x = cmd.pt_rd ? idx_x_ff : scan_addr_ff;
   assign ra_y = cmd.pt_rd ? idx_y_ff : scan_addr_ff;
   assign clr  = scan_run_ff && (kind_ff == PASS_CLEAR);

   always_ff @(posedge clock) begin
      rd_x_ff <= x_hist_mem[ra_x];
      rd_y_ff <= y_hist_mem[ra_y];
      if (clr) begin
         x_hist_mem[scan_addr_ff] <= '0;
         y_hist_mem[scan_addr_ff] <= '0;
      end else if (cmd.pt_wr) begin
         if (hit_x_ff) begin
            x_hist_mem[idx_x_ff] <= (rd_x_ff == COUNT_MAX) ? rd_x_ff : rd_x_ff + 1'b1;
         end
         if (hit_y_ff) begin
            y_hist_mem[idx_y_ff] <= (rd_y_ff == COUNT_MAX) ? rd_y_ff : rd_y_ff + 1'b1;
         end
      end
   end

   // Per-entry tests on the word coming out of memory.
   logic          in_x, in_y, nz_x, nz_y, bel_x, bel_y, le_hit_x, le_hit_y;
   logic [CB-1:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff, mid_x, mid_y;
   logic [CB:0]   sum_x, sum_y;
   logic [TW-1:0] thr_x_ff, thr_y_ff;

   always_comb begin
      sum_x    = {1'b0, lo_x_ff} + {1'b0, hi_x_ff};
      sum_y    = {1'b0, lo_y_ff} + {1'b0, hi_y_ff};
      mid_x    = sum_x[CB:1];
      mid_y    = sum_y[CB:1];
      in_x     = NB'(rd_idx_ff) < nx_ff;
      in_y     = NB'(rd_idx_ff) < ny_ff;
      nz_x     = rd_x_ff != '0;
      nz_y     = rd_y_ff != '0;
      le_hit_x = in_x && nz_x && (rd_x_ff <= mid_x);
      le_hit_y = in_y && nz_y && (rd_y_ff <= mid_y);
      bel_x    = TW'({rd_x_ff, 16'd0}) < thr_x_ff;
      bel_y    = TW'({rd_y_ff, 16'd0}) < thr_y_ff;
   end

   // Sweep accumulators and median search.
   logic [NB-1:0] cnt_x_ff, cnt_y_ff, k_x_ff, k_y_ff;
   logic          empty_x_ff, empty_y_ff;
   logic [NB-1:0] first_x_ff, first_y_ff, last_x_ff, last_y_ff;
   logic          found_x_ff, found_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         cnt_x_ff   <= '0;
         cnt_y_ff   <= '0;
         found_x_ff <= 1'b0;
         found_y_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         case (kind_ff)
            PASS_COUNT: begin
               cnt_x_ff <= cnt_x_ff + NB'(in_x && nz_x);
               cnt_y_ff <= cnt_y_ff + NB'(in_y && nz_y);
            end
            PASS_SEARCH: begin
               cnt_x_ff <= cnt_x_ff + NB'(le_hit_x);
               cnt_y_ff <= cnt_y_ff + NB'(le_hit_y);
            end
            PASS_TRIM: begin
               if (in_x && !bel_x) begin
                  if (!found_x_ff) first_x_ff <= NB'(rd_idx_ff);
                  last_x_ff  <= NB'(rd_idx_ff);
                  found_x_ff <= 1'b1;
               end
               if (in_y && !bel_y) begin
                  if (!found_y_ff) first_y_ff <= NB'(rd_idx_ff);
                  last_y_ff  <= NB'(rd_idx_ff);
                  found_y_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // Start of median search: the non-zero count sets the rank.
      if (cmd.cnt_fin) begin
         k_x_ff     <= cnt_x_ff >> 1;
         k_y_ff     <= cnt_y_ff >> 1;
         empty_x_ff <= cnt_x_ff == '0;
         empty_y_ff <= cnt_y_ff == '0;
         lo_x_ff    <= (cnt_x_ff == '0) ? '0 : CB'(1);
         hi_x_ff    <= (cnt_x_ff == '0) ? '0 : COUNT_MAX;
         lo_y_ff    <= (cnt_y_ff == '0) ? '0 : CB'(1);
         hi_y_ff    <= (cnt_y_ff == '0) ? '0 : COUNT_MAX;
      end
      // One bisection step per axis after each search sweep.
      if (cmd.srch_upd) begin
         if (lo_x_ff < hi_x_ff) begin
            if (cnt_x_ff > k_x_ff) hi_x_ff <= mid_x;
            else                   lo_x_ff <= mid_x + 1'b1;
         end
         if (lo_y_ff < hi_y_ff) begin
            if (cnt_y_ff > k_y_ff) hi_y_ff <= mid_y;
            else                   lo_y_ff <= mid_y + 1'b1;
         end
      end
      // Threshold is tolerance times median.
      if (cmd.thr_mul) begin
         thr_x_ff <= TW'(trim_tol) * TW'(lo_x_ff);
         thr_y_ff <= TW'(trim_tol) * TW'(lo_y_ff);
      end
   end

   // Run lengths from each side, scaled to micrometers.
   logic [NB-1:0] a_x, b_x, a_y, b_y;
   logic [PW-1:0] p_w, p_e, p_s, p_n;

   always_comb begin
      a_x = found_x_ff ? first_x_ff : nx_ff;
      b_x = found_x_ff ? nx_ff - 1'b1 - last_x_ff : nx_ff;
      a_y = found_y_ff ? first_y_ff : ny_ff;
      b_y = found_y_ff ? ny_ff - 1'b1 - last_y_ff : ny_ff;
      p_w = PW'(a_x) * PW'(eff_w);
      p_e = PW'(b_x) * PW'(eff_w);
      p_s = PW'(a_y) * PW'(eff_w);
      p_n = PW'(b_y) * PW'(eff_w);
   end

   always_ff @(posedge clock) begin
      if (cmd.trim_mul) begin
         trim_west    <= TRIM_W'(p_w);
         trim_east    <= TRIM_W'(p_e);
         trim_south   <= TRIM_W'(p_s);
         trim_north   <= TRIM_W'(p_n);
         no_data      <= empty_x_ff | empty_y_ff;
         bins_clamped <= clamp_x_ff | clamp_y_ff;
      end
   end

   // Status back to the controller.
   always_comb begin
      status.div_done  = div_done;
      status.bins_ok   = bins_ok_ff;
      status.pass_done = rd_vld_ff && rd_last_ff;
      status.srch_done = (lo_x_ff >= hi_x_ff) && (lo_y_ff >= hi_y_ff);
   end

endmodule

@@ design/pcea_ctrl.sv @@
// Controller: sequences divisions, histogram updates and finish sweeps.
// Uses command and status types from pcea_pkg.
module pcea_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pcea_pkg::TYPE_W-1:0]        req_type,
   output logic                               busy,
   output logic                               rsp_valid,
   output pcea_pkg::pcea_cmd_type             cmd,
   input  pcea_pkg::pcea_status_type          status
);
   import pcea_pkg::*;

   typedef enum logic [4:0] {
      ST_RST_GO, ST_RST_WAIT, ST_IDLE,
      ST_BX_GO, ST_BX_WAIT, ST_BY_GO, ST_BY_WAIT,
      ST_IX_GO, ST_IX_WAIT, ST_IY_GO, ST_IY_WAIT,
      ST_PT_RD, ST_PT_WR,
      ST_CNT_GO, ST_CNT_WAIT, ST_CNT_FIN,
      ST_SRCH_CHK, ST_SRCH_GO, ST_SRCH_WAIT, ST_SRCH_UPD,
      ST_THR, ST_TRIM_GO, ST_TRIM_WAIT, ST_TRIM_MUL,
      ST_CLR_GO, ST_CLR_WAIT, ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      finish_ff, finish_in;
   logic      busy_ff, valid_ff;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_RST_GO: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_CLEAR;
            state_in       = ST_RST_WAIT;
         end
         ST_RST_WAIT: if (status.pass_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               unique case (req_type)
                  REQ_EXTENT: cmd.ext_upd = 1'b1;
                  REQ_COUNT: begin
                     cmd.pt_load = 1'b1;
                     finish_in   = 1'b0;
                     state_in    = status.bins_ok ? ST_IX_GO : ST_BX_GO;
                  end
                  REQ_FINISH: begin
                     finish_in = 1'b1;
                     state_in  = status.bins_ok ? ST_CNT_GO : ST_BX_GO;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_BX_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BINS_X;
            state_in      = ST_BX_WAIT;
         end
         ST_BX_WAIT: begin
            cmd.div_sel = DIV_BINS_X;
            if (status.div_done) state_in = ST_BY_GO;
         end
         ST_BY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BINS_Y;
            state_in      = ST_BY_WAIT;
         end
         ST_BY_WAIT: begin
            cmd.div_sel = DIV_BINS_Y;
            if (status.div_done) state_in = finish_ff ? ST_CNT_GO : ST_IX_GO;
         end
         ST_IX_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_IDX_X;
            state_in      = ST_IX_WAIT;
         end
         ST_IX_WAIT: begin
            cmd.div_sel = DIV_IDX_X;
            if (status.div_done) state_in = ST_IY_GO;
         end
         ST_IY_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_IDX_Y;
            state_in      = ST_IY_WAIT;
         end
         ST_IY_WAIT: begin
            cmd.div_sel = DIV_IDX_Y;
            if (status.div_done) state_in = ST_PT_RD;
         end
         ST_PT_RD: begin
            cmd.pt_rd = 1'b1;
            state_in  = ST_PT_WR;
         end
         ST_PT_WR: begin
            cmd.pt_wr = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_CNT_GO: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_COUNT;
            state_in       = ST_CNT_WAIT;
         end
         ST_CNT_WAIT: if (status.pass_done) state_in = ST_CNT_FIN;
         ST_CNT_FIN: begin
            cmd.cnt_fin = 1'b1;
            state_in    = ST_SRCH_CHK;
         end
         ST_SRCH_CHK: state_in = status.srch_done ? ST_THR : ST_SRCH_GO;
         ST_SRCH_GO: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_SEARCH;
            state_in       = ST_SRCH_WAIT;
         end
         ST_SRCH_WAIT: if (status.pass_done) state_in = ST_SRCH_UPD;
         ST_SRCH_UPD: begin
            cmd.srch_upd = 1'b1;
            state_in     = ST_SRCH_CHK;
         end
         ST_THR: begin
            cmd.thr_mul = 1'b1;
            state_in    = ST_TRIM_GO;
         end
         ST_TRIM_GO: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_TRIM;
            state_in       = ST_TRIM_WAIT;
         end
         ST_TRIM_WAIT: if (status.pass_done) state_in = ST_TRIM_MUL;
         ST_TRIM_MUL: begin
            cmd.trim_mul = 1'b1;
            state_in     = ST_CLR_GO;
         end
         ST_CLR_GO: begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_CLEAR;
            state_in       = ST_CLR_WAIT;
         end
         ST_CLR_WAIT: if (status.pass_done) state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RST_GO;
         finish_ff <= 1'b0;
         busy_ff   <= 1'b1;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
         busy_ff   <= state_in != ST_IDLE;
         valid_ff  <= state_in == ST_REPORT;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

@@ design/point_cloud_edge_autotrim_top.sv @@
// Top level of the point cloud edge trim block.
// Depends on pcea_pkg, pcea_csr, pcea_ctrl and pcea_datapath.
//
// Usage: a word is taken at a clock edge with start high and busy low.
// req_type selects an extent point, a count point or a finish request.
// An extent point updates the x/y minimum and maximum and leaves busy
// low. A count point runs two bin-index divisions on the shared
// one-bit-per-cycle divider and a memory read-modify-write with busy
// high; when the extent or bin width has changed since the last bin
// count, two more divisions come first. A finish sweeps both histogram
// memories, one entry per cycle: one counting sweep, up to COUNT_BITS
// bisection sweeps for the median, one trim sweep and one clearing sweep.
// It then shows one result word for one cycle with rsp_valid high; the
// receiver cannot stall it. After reset the memories are cleared in a
// pass with busy high. The user must write configuration on the APB-style
// port only while busy is low and no finish is in progress; the block
// itself does not enforce this.
module point_cloud_edge_autotrim_top #(
   parameter int MAX_BINS   = pcea_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = pcea_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pcea_pkg::TYPE_W-1:0]         req_type,
   input  logic signed [pcea_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [pcea_pkg::COORD_W-1:0] req_point_y,
   output logic                                rsp_valid,
   output logic [pcea_pkg::TRIM_W-1:0]         rsp_trim_north,
   output logic [pcea_pkg::TRIM_W-1:0]         rsp_trim_south,
   output logic [pcea_pkg::TRIM_W-1:0]         rsp_trim_east,
   output logic [pcea_pkg::TRIM_W-1:0]         rsp_trim_west,
   output logic                                rsp_no_data,
   output logic                                rsp_bins_clamped,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcea_pkg::CSR_AW-1:0]         paddr,
   input  logic [pcea_pkg::CSR_DW-1:0]         pwdata,
   output logic [pcea_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import pcea_pkg::*;

   logic [BW_W-1:0]  bin_width;
   logic [TOL_W-1:0] trim_tol;
   logic             width_wr;
   pcea_cmd_type     cmd;
   pcea_status_type  status;

   pcea_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .bin_width (bin_width),
      .trim_tol  (trim_tol),
      .width_wr  (width_wr)
   );

   pcea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   pcea_datapath #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .point_x      (req_point_x),
      .point_y      (req_point_y),
      .bin_width    (bin_width),
      .trim_tol     (trim_tol),
      .width_wr     (width_wr),
      .trim_north   (rsp_trim_north),
      .trim_south   (rsp_trim_south),
      .trim_east    (rsp_trim_east),
      .trim_west    (rsp_trim_west),
      .no_data      (rsp_no_data),
      .bins_clamped (rsp_bins_clamped)
   );

endmodule
